// ===== rtl/ses_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ses_pkg: shared types and constants of the state space Euler integrator
// Holds the payload structs, register indexes, reset values, sequencer step
// codes and the 34-bit saturation helper used by the integrator core.
// ----------------------------------------------------------------------------
package ses_pkg;

  // Widths of the datapath.
  localparam int DATA_W    = 32;
  localparam int DT_W      = 24;
  localparam int ACC_W     = 34;
  localparam int MUL_A_W   = 33;
  localparam int PROD_W    = 65;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_V_V     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_V_ANGLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W_V     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W_ANGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_V       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_W       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd6;

  // Register reset values.
  localparam logic signed [DATA_W-1:0] RST_COEF_V_V     = -32'sd567096;
  localparam logic signed [DATA_W-1:0] RST_COEF_V_ANGLE = -32'sd174442;
  localparam logic signed [DATA_W-1:0] RST_COEF_W_V     = 32'sd2077274;
  localparam logic signed [DATA_W-1:0] RST_COEF_W_ANGLE = 32'sd2991557;
  localparam logic signed [DATA_W-1:0] RST_GAIN_V       = 32'sd43999;
  localparam logic signed [DATA_W-1:0] RST_GAIN_W       = -32'sd161168;
  localparam logic [DT_W-1:0]          RST_TIME_STEP    = 24'd16777;

  // Sequencer steps: one multiplier issue per step.
  localparam logic [STEP_W-1:0] STEP_A11  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_A12  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_B1   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_A31  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_A32  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_B3   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_E1   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_E0   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_E3   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_E2   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd11;
  localparam logic [STEP_W-1:0] MUL_LAT   = 4'd2;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] drive_position;
    logic signed [DATA_W-1:0] drive_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_out;
    logic signed [DATA_W-1:0] vel_out;
    logic signed [DATA_W-1:0] angle_out;
    logic signed [DATA_W-1:0] rate_out;
    logic                     updated;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] coef_v_v;
    logic signed [DATA_W-1:0] coef_v_angle;
    logic signed [DATA_W-1:0] coef_w_v;
    logic signed [DATA_W-1:0] coef_w_angle;
    logic signed [DATA_W-1:0] gain_v;
    logic signed [DATA_W-1:0] gain_w;
    logic [DT_W-1:0]          time_step;
  } cfg_regs_t;

  // Request to the shared multiplier: dt_mode selects Q0.24 rounding.
  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [DATA_W-1:0]  b;
    logic                      dt_mode;
  } mul_req_t;

  // A saturated 32-bit value and whether it clipped.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clip;
  } sat_val_t;

  // Saturate a 34-bit sum to 32 bits.
  function automatic sat_val_t sat_acc(input logic signed [ACC_W-1:0] v);
    sat_val_t r;
    if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
      r.value = v[DATA_W-1:0];
      r.clip  = 1'b0;
    end else begin
      r.value = v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      r.clip  = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/state_space_euler_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// state_space_euler_step: four-state forward Euler integrator
// Advances x' = A x + B u by one step per armed tick transaction, in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one transaction per tick or
//   restart request. Result channel (out_valid / out_stall / out_data): one
//   transaction per input, carrying the four states after that input.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   cfg_ready is always high; write only while the block is idle.
// Sequencing:
//   An integrating tick runs the issue and drain steps of the single shared
//   33x32 multiplier (six matrix products and four time step products,
//   two-stage pipeline), then the load state writes the output register.
//   A restart or arming tick goes from acceptance straight to the load state.
//   in_stall stays high until the result is loaded, so the next input waits.
// Reset:
//   States clear to zero, the block is disarmed and the registers take their
//   default coefficients. The first tick after reset or restart only arms.
// Stall:
//   A stalled result holds in the output register; the block still accepts one
//   more input and finishes its work, then waits until the register is free.
// ----------------------------------------------------------------------------
module state_space_euler_step (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  ses_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output ses_pkg::out_item_t               out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [ses_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [ses_pkg::DATA_W-1:0]        cfg_data
);
  import ses_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_DONE} state_t;

  state_t                   state_r;
  logic [STEP_W-1:0]        step_cnt_r;
  logic                     armed_r;
  logic                     upd_r;
  logic                     clip_r;
  logic signed [DATA_W-1:0] x_r [4];
  logic signed [DATA_W-1:0] u_r;
  logic signed [ACC_W-1:0]  acc1_r;
  logic signed [ACC_W-1:0]  acc3_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  cfg_regs_t                regs;
  mul_req_t                 mul_req;
  sat_val_t                 mul_rsp;
  sat_val_t                 u_sat;
  sat_val_t                 dx1_sat;
  sat_val_t                 dx3_sat;
  sat_val_t                 euler_sat;
  logic [STEP_W-1:0]        res_step;
  logic [1:0]               tgt_idx;
  logic signed [ACC_W-1:0]  res_ext;
  logic                     clip_nxt;

  // Configuration registers.
  ses_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  // Shared arithmetic unit.
  ses_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Drive sum and the saturated derivatives.
  always_comb begin
    u_sat   = sat_acc({{2{in_data.drive_position[DATA_W-1]}}, in_data.drive_position}
                    + {{2{in_data.drive_rate[DATA_W-1]}}, in_data.drive_rate});
    dx1_sat = sat_acc(acc1_r);
    dx3_sat = sat_acc(acc3_r);
  end

  // Multiplier issue, selected by the sequencer step.
  always_comb begin
    mul_req.a       = '0;
    mul_req.b       = '0;
    mul_req.dt_mode = 1'b0;
    unique case (step_cnt_r)
      STEP_A11: begin
        mul_req.a = {regs.coef_v_v[DATA_W-1], regs.coef_v_v};
        mul_req.b = x_r[1];
      end
      STEP_A12: begin
        mul_req.a = {regs.coef_v_angle[DATA_W-1], regs.coef_v_angle};
        mul_req.b = x_r[2];
      end
      STEP_B1: begin
        mul_req.a = {regs.gain_v[DATA_W-1], regs.gain_v};
        mul_req.b = u_r;
      end
      STEP_A31: begin
        mul_req.a = {regs.coef_w_v[DATA_W-1], regs.coef_w_v};
        mul_req.b = x_r[1];
      end
      STEP_A32: begin
        mul_req.a = {regs.coef_w_angle[DATA_W-1], regs.coef_w_angle};
        mul_req.b = x_r[2];
      end
      STEP_B3: begin
        mul_req.a = {regs.gain_w[DATA_W-1], regs.gain_w};
        mul_req.b = u_r;
      end
      STEP_E1: begin
        mul_req.a       = {{(MUL_A_W-DT_W){1'b0}}, regs.time_step};
        mul_req.b       = dx1_sat.value;
        mul_req.dt_mode = 1'b1;
      end
      STEP_E0: begin
        mul_req.a       = {{(MUL_A_W-DT_W){1'b0}}, regs.time_step};
        mul_req.b       = x_r[1];
        mul_req.dt_mode = 1'b1;
      end
      STEP_E3: begin
        mul_req.a       = {{(MUL_A_W-DT_W){1'b0}}, regs.time_step};
        mul_req.b       = dx3_sat.value;
        mul_req.dt_mode = 1'b1;
      end
      STEP_E2: begin
        mul_req.a       = {{(MUL_A_W-DT_W){1'b0}}, regs.time_step};
        mul_req.b       = x_r[3];
        mul_req.dt_mode = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result side: which step the unit's output belongs to, and the Euler add.
  always_comb begin
    res_step = step_cnt_r - MUL_LAT;
    res_ext  = {{2{mul_rsp.value[DATA_W-1]}}, mul_rsp.value};
    unique case (res_step)
      STEP_E0: tgt_idx = 2'd0;
      STEP_E1: tgt_idx = 2'd1;
      STEP_E2: tgt_idx = 2'd2;
      default: tgt_idx = 2'd3;
    endcase
    euler_sat = sat_acc({{2{x_r[tgt_idx][DATA_W-1]}}, x_r[tgt_idx]} + res_ext);
  end

  // Clip flag collected over the whole step.
  always_comb begin
    clip_nxt = clip_r;
    if (step_cnt_r == STEP_E1) begin
      clip_nxt = clip_nxt | dx1_sat.clip;
    end
    if (step_cnt_r == STEP_E3) begin
      clip_nxt = clip_nxt | dx3_sat.clip;
    end
    if (step_cnt_r >= MUL_LAT) begin
      unique case (res_step)
        STEP_E0, STEP_E1, STEP_E2, STEP_E3: clip_nxt = clip_nxt | euler_sat.clip;
        default:                            clip_nxt = clip_nxt | mul_rsp.clip;
      endcase
    end
  end

  // Sequencer, state registers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_cnt_r  <= '0;
      armed_r     <= 1'b0;
      upd_r       <= 1'b0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
      x_r[0]      <= '0;
      x_r[1]      <= '0;
      x_r[2]      <= '0;
      x_r[3]      <= '0;
    end else begin
      // The load state refills the output register itself.
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.req_type) begin
              armed_r <= 1'b0;
              upd_r   <= 1'b0;
              clip_r  <= 1'b0;
              state_r <= ST_DONE;
            end else if (!armed_r) begin
              armed_r <= 1'b1;
              upd_r   <= 1'b0;
              clip_r  <= 1'b0;
              state_r <= ST_DONE;
            end else begin
              u_r        <= u_sat.value;
              clip_r     <= u_sat.clip;
              upd_r      <= 1'b1;
              step_cnt_r <= '0;
              state_r    <= ST_BUSY;
            end
          end
        end
        ST_BUSY: begin
          step_cnt_r <= step_cnt_r + 1'b1;
          clip_r     <= clip_nxt;
          if (step_cnt_r == STEP_LAST) begin
            state_r <= ST_DONE;
          end
          if (step_cnt_r >= MUL_LAT) begin
            unique case (res_step)
              STEP_A11:         acc1_r <= res_ext;
              STEP_A12, STEP_B1: acc1_r <= acc1_r + res_ext;
              STEP_A31:         acc3_r <= res_ext;
              STEP_A32, STEP_B3: acc3_r <= acc3_r + res_ext;
              STEP_E0, STEP_E1, STEP_E2, STEP_E3: x_r[tgt_idx] <= euler_sat.value;
              default: begin
              end
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.pos_out   <= x_r[0];
            out_data_r.vel_out   <= x_r[1];
            out_data_r.angle_out <= x_r[2];
            out_data_r.rate_out  <= x_r[3];
            out_data_r.updated   <= upd_r;
            out_data_r.saturated <= clip_r;
            out_valid_r          <= 1'b1;
            state_r              <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The step counter never runs past the last drain step.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BUSY) |-> (step_cnt_r <= STEP_LAST))
    else $error("sequencer step out of range");

  // An armed tick always starts the integration sequence.
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_data.req_type && armed_r) |=> (state_r == ST_BUSY))
    else $error("armed tick did not start integration");

  // Clipping is only possible on an integrating tick.
  a_clip_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |-> out_data.updated)
    else $error("saturation reported without an update");

  // A new result only appears from the load state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == ST_DONE))
    else $error("result shown outside the load state");

endmodule
`default_nettype wire

// ===== rtl/ses_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ses_cfg: configuration register file
// Decodes register writes by index; writes past the last register are dropped.
// ----------------------------------------------------------------------------
module ses_cfg (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               wr_en,
  input  wire [ses_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire [ses_pkg::DATA_W-1:0]         wr_data,
  output ses_pkg::cfg_regs_t                regs
);
  import ses_pkg::*;

  cfg_regs_t regs_r;

  // Register writes, one per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.coef_v_v     <= RST_COEF_V_V;
      regs_r.coef_v_angle <= RST_COEF_V_ANGLE;
      regs_r.coef_w_v     <= RST_COEF_W_V;
      regs_r.coef_w_angle <= RST_COEF_W_ANGLE;
      regs_r.gain_v       <= RST_GAIN_V;
      regs_r.gain_w       <= RST_GAIN_W;
      regs_r.time_step    <= RST_TIME_STEP;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_COEF_V_V:     regs_r.coef_v_v     <= wr_data;
        REG_COEF_V_ANGLE: regs_r.coef_v_angle <= wr_data;
        REG_COEF_W_V:     regs_r.coef_w_v     <= wr_data;
        REG_COEF_W_ANGLE: regs_r.coef_w_angle <= wr_data;
        REG_GAIN_V:       regs_r.gain_v       <= wr_data;
        REG_GAIN_W:       regs_r.gain_w       <= wr_data;
        REG_TIME_STEP:    regs_r.time_step    <= wr_data[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign regs = regs_r;

endmodule
`default_nettype wire

// ===== rtl/ses_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ses_mul: shared multiply, round and saturate unit
// Two-stage pipeline: a registered 33x32 signed product, then round half up
// by 2^16 (Q16.16 product) or 2^24 (time step product) and saturate to 32 bits.
// ----------------------------------------------------------------------------
module ses_mul (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ses_pkg::mul_req_t    req,
  output ses_pkg::sat_val_t    rsp
);
  import ses_pkg::*;

  localparam int RND_W = PROD_W + 1;
  localparam logic signed [RND_W-1:0] RND_Q  = 66'sh8000;
  localparam logic signed [RND_W-1:0] RND_DT = 66'sh800000;

  logic signed [PROD_W-1:0] prod_r;
  logic                     mode_r;
  sat_val_t                 rsp_r;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  shifted;

  // Stage one: the product.
  always_ff @(posedge clk) begin
    prod_r <= $signed(req.a) * $signed(req.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= req.dt_mode;
    end
  end

  // Stage two: round, shift and saturate.
  always_comb begin
    rnd     = $signed({prod_r[PROD_W-1], prod_r}) + (mode_r ? RND_DT : RND_Q);
    shifted = mode_r ? (rnd >>> DT_W) : (rnd >>> 16);
  end

  always_ff @(posedge clk) begin
    if (shifted[RND_W-1:DATA_W-1] == '0 || shifted[RND_W-1:DATA_W-1] == '1) begin
      rsp_r.value <= shifted[DATA_W-1:0];
      rsp_r.clip  <= 1'b0;
    end else begin
      rsp_r.value <= shifted[RND_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
      rsp_r.clip  <= 1'b1;
    end
  end

  assign rsp = rsp_r;

  // A time step product is always in range, so it never reports a clip.
  a_dt_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |=> !rsp.clip)
    else $error("time step product reported a clip");

endmodule
`default_nettype wire

// ===== tb/state_space_euler_step_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_space_euler_step_test: self-checking bench for the Euler integrator
// Drives tick and restart transactions with random gaps while the result side
// stalls at random. A plant tracker class predicts the four states, updated
// and saturated flags for every accepted request. The registers are
// reprogrammed between phases, covering the reset values, random values and
// both extremes.
// ----------------------------------------------------------------------------
module state_space_euler_step_test;
  import ses_pkg::*;

  localparam int PHASE_COUNT  = 9;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  // Index one past the last register, which the block must ignore.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef enum int {
    CFG_DEFAULT,
    CFG_SMALL,
    CFG_RANDOM,
    CFG_MIXED,
    CFG_MAX,
    CFG_MIN
  } cfg_kind_e;

  // Tracks the plant state and holds the states expected from the block.
  class plant_tracker;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    longint a11, a12, a31, a32, b1, b3, dt;
    longint x [4];
    bit armed;
    out_item_t expected_states [$];
    int errors;

    function new();
      a11 = longint'(RST_COEF_V_V);
      a12 = longint'(RST_COEF_V_ANGLE);
      a31 = longint'(RST_COEF_W_V);
      a32 = longint'(RST_COEF_W_ANGLE);
      b1  = longint'(RST_GAIN_V);
      b3  = longint'(RST_GAIN_W);
      dt  = longint'(RST_TIME_STEP);
      foreach (x[i]) x[i] = 0;
      armed  = 1'b0;
      errors = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_COEF_V_V:     a11 = longint'($signed(data));
        REG_COEF_V_ANGLE: a12 = longint'($signed(data));
        REG_COEF_W_V:     a31 = longint'($signed(data));
        REG_COEF_W_ANGLE: a32 = longint'($signed(data));
        REG_GAIN_V:       b1  = longint'($signed(data));
        REG_GAIN_W:       b3  = longint'($signed(data));
        REG_TIME_STEP:    dt  = longint'(data[DT_W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clip32(longint v, inout bit hit);
      if (v > SAT_HI) begin
        hit = 1'b1;
        return SAT_HI;
      end
      if (v < SAT_LO) begin
        hit = 1'b1;
        return SAT_LO;
      end
      return v;
    endfunction

    // Round half up, then shift right with floor.
    function longint round_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint coef_mul(longint c, longint v, inout bit hit);
      return clip32(round_shift(c * v, 16), hit);
    endfunction

    function longint euler_add(longint v, longint dv, inout bit hit);
      return clip32(v + round_shift(dv * dt, DT_W), hit);
    endfunction

    // Advance the plant for one accepted request and queue the result.
    function void note_request(in_item_t req);
      out_item_t want;
      bit hit;
      bit stepped;
      longint u, dx1, dx3, n0, n1, n2, n3;
      hit = 1'b0;
      stepped = 1'b0;
      if (req.req_type == REQ_RESTART) begin
        armed = 1'b0;
      end else if (!armed) begin
        armed = 1'b1;
      end else begin
        u = clip32(longint'($signed(req.drive_position)) +
                   longint'($signed(req.drive_rate)), hit);
        dx1 = clip32(coef_mul(a11, x[1], hit) + coef_mul(a12, x[2], hit) +
                     coef_mul(b1, u, hit), hit);
        dx3 = clip32(coef_mul(a31, x[1], hit) + coef_mul(a32, x[2], hit) +
                     coef_mul(b3, u, hit), hit);
        n0 = euler_add(x[0], x[1], hit);
        n1 = euler_add(x[1], dx1, hit);
        n2 = euler_add(x[2], x[3], hit);
        n3 = euler_add(x[3], dx3, hit);
        x[0] = n0;
        x[1] = n1;
        x[2] = n2;
        x[3] = n3;
        stepped = 1'b1;
      end
      want.pos_out   = x[0][DATA_W-1:0];
      want.vel_out   = x[1][DATA_W-1:0];
      want.angle_out = x[2][DATA_W-1:0];
      want.rate_out  = x[3][DATA_W-1:0];
      want.updated   = stepped;
      want.saturated = hit;
      expected_states.push_back(want);
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (got !== want) begin
        errors++;
        $error("%s mismatch: expected %h, actual %h", name, want, got);
      end
    endfunction

    // Compare one accepted result against the oldest expectation.
    function void check_states(out_item_t got);
      out_item_t want;
      if (expected_states.size() == 0) begin
        errors++;
        $error("result transaction with no request outstanding: %h", got);
        return;
      end
      want = expected_states.pop_front();
      compare_field("pos_out", want.pos_out, got.pos_out);
      compare_field("vel_out", want.vel_out, got.vel_out);
      compare_field("angle_out", want.angle_out, got.angle_out);
      compare_field("rate_out", want.rate_out, got.rate_out);
      compare_field("updated", 32'(want.updated), 32'(got.updated));
      compare_field("saturated", 32'(want.saturated), 32'(got.saturated));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  plant_tracker board;
  bit hold_request = 1'b0;
  int cycles = 0;

  cfg_kind_e phase_plan [PHASE_COUNT] = '{CFG_DEFAULT, CFG_SMALL, CFG_RANDOM,
                                          CFG_SMALL, CFG_MIXED, CFG_MAX,
                                          CFG_MIN, CFG_RANDOM, CFG_DEFAULT};

  state_space_euler_step DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Observe every transaction on the three channels.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_valid && cfg_ready) board.apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) board.note_request(in_data);
      if (out_valid && !out_stall) board.check_states(out_data);
    end
  end

  // Result-side stall pattern, including one long hold-off on request.
  initial begin : result_stall_gen
    int sel;
    int len;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
          out_stall <= 1'b0;
          len = $urandom_range(40, 150);
        end else if (sel < 55) begin
          out_stall <= 1'b1;
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 6);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [DATA_W-1:0] rand_drive();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $urandom();
    if (sel < 70) return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
    if (sel < 85) return 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
    case ($urandom_range(0, 4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return '1;
      default: return 32'd1;
    endcase
  endfunction

  function automatic in_item_t make_item(logic req, logic [DATA_W-1:0] pos,
                                         logic [DATA_W-1:0] rate);
    in_item_t it;
    it.req_type       = req;
    it.drive_position = pos;
    it.drive_rate     = rate;
    return it;
  endfunction

  function automatic in_item_t random_item();
    return make_item(($urandom_range(0, 19) == 0) ? REQ_RESTART : REQ_TICK,
                     rand_drive(), rand_drive());
  endfunction

  function automatic logic [DATA_W-1:0] coef_extreme();
    case ($urandom_range(0, 3))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return $urandom();
    endcase
  endfunction

  // Offer one request transaction and hold it until accepted.
  task automatic send_item(input in_item_t it, input int gap);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every result has come back and the block has gone quiet.
  task automatic wait_idle();
    while (board.expected_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers, plus the unused index, back to back.
  task automatic program_config(input cfg_kind_e kind);
    logic [DATA_W-1:0] vals [8];
    int i;
    for (i = 0; i <= REG_UNUSED; i++) begin
      case (kind)
        CFG_SMALL:  vals[i] = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        CFG_MIXED:  vals[i] = coef_extreme();
        CFG_MAX:    vals[i] = Q_MAX;
        CFG_MIN:    vals[i] = Q_MIN;
        default:    vals[i] = $urandom();
      endcase
    end
    if (kind == CFG_DEFAULT) begin
      vals[REG_COEF_V_V]     = RST_COEF_V_V;
      vals[REG_COEF_V_ANGLE] = RST_COEF_V_ANGLE;
      vals[REG_COEF_W_V]     = RST_COEF_W_V;
      vals[REG_COEF_W_ANGLE] = RST_COEF_W_ANGLE;
      vals[REG_GAIN_V]       = RST_GAIN_V;
      vals[REG_GAIN_W]       = RST_GAIN_W;
      vals[REG_TIME_STEP]    = {8'($urandom()), RST_TIME_STEP};
    end
    // The upper byte of the time step write is random and must be dropped.
    if (kind == CFG_MAX) vals[REG_TIME_STEP] = {8'($urandom()), 24'hFF_FFFF};
    if (kind == CFG_MIN) vals[REG_TIME_STEP] = {8'($urandom()), 24'h00_0000};
    for (i = 0; i <= REG_UNUSED; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : main_seq
    in_item_t directed [$];
    int gap;
    int p;
    int n;
    board = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with reset registers: arming, drive extremes and restarts.
    directed.push_back(make_item(REQ_TICK, '0, '0));
    directed.push_back(make_item(REQ_TICK, '0, '0));
    directed.push_back(make_item(REQ_TICK, Q_MAX, Q_MAX));
    directed.push_back(make_item(REQ_TICK, Q_MIN, Q_MIN));
    directed.push_back(make_item(REQ_TICK, Q_MAX, Q_MIN));
    directed.push_back(make_item(REQ_TICK, '1, 32'd1));
    directed.push_back(make_item(REQ_RESTART, Q_MAX, Q_MIN));
    directed.push_back(make_item(REQ_RESTART, '0, '0));
    directed.push_back(make_item(REQ_TICK, Q_MAX, '0));
    directed.push_back(make_item(REQ_TICK, Q_MIN, '0));
    directed.push_back(make_item(REQ_TICK, 32'd1, '1));
    directed.push_back(make_item(REQ_TICK, 32'h0001_0000, 32'h0001_0000));
    directed.push_back(make_item(REQ_RESTART, $urandom(), $urandom()));
    directed.push_back(make_item(REQ_TICK, $urandom(), $urandom()));
    directed.push_back(make_item(REQ_TICK, $urandom(), $urandom()));
    foreach (directed[i]) begin
      gap = pick_gap();
      if (i == directed.size() - 1 && gap == 0) gap = 1;
      send_item(directed[i], gap);
    end

    // Random phases, each under its own register setting.
    for (p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      program_config(phase_plan[p]);
      if (p == 2) hold_request = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Keep offering during the long hold-off so the block backs up.
        gap = (p == 2 && n < 40) ? 0 : pick_gap();
        if (n == PHASE_ITEMS - 1 && gap == 0) gap = 1;
        send_item(random_item(), gap);
      end
    end

    wait_idle();
    if (board.errors == 0 && board.expected_states.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ses_pkg.sv
rtl/ses_cfg.sv
rtl/ses_mul.sv
rtl/state_space_euler_step.sv
tb/state_space_euler_step_test.sv
